### sv/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg: shared types and codes for the Huffman tree walk decoder
// Request and response payloads, operation codes and the step control bundle.
// ----------------------------------------------------------------------------
package htw_pkg;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_DECODE  = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Highest bit count a decode item may carry; larger counts saturate.
   localparam logic [3:0] MAX_BITS = 4'd8;
   localparam int         TOP_BIT  = 7;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] node_index;
      logic [7:0] left_child;
      logic [7:0] right_child;
      logic [6:0] leaf_symbol;
      logic [7:0] data_byte;
      logic [3:0] bit_count;
   } req_type;

   typedef struct packed {
      logic [6:0] symbol;
      logic       symbol_valid;
      logic       bad_code;
      logic       last;
   } rsp_type;

   // Decision of one walk cycle.
   typedef struct packed {
      logic leaf_hit;   // node just reached is a leaf: emit its symbol
      logic bad;        // bit pointed at an absent child
      logic consume;    // one coded bit is used this cycle
      logic done;       // no bits left and nothing pending to test
   } step_ctl_type;

endpackage

### sv/htw_ram.sv
// ----------------------------------------------------------------------------
// htw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/htw_step.sv
// ----------------------------------------------------------------------------
// htw_step: tree walk step unit
// Tests the node just reached for a leaf, else picks the child for one bit or flags done.
// ----------------------------------------------------------------------------
module htw_step #(
   parameter int NODE_W = 8
) (
   input  logic [2*NODE_W+8:0]  entry,
   input  logic                 chk,
   input  logic [3:0]           bits_left,
   input  logic                 bit_in,
   output htw_pkg::step_ctl_type ctl,
   output logic [NODE_W-1:0]    next_idx
);

   typedef struct packed {
      logic              lpres;
      logic [NODE_W-1:0] lidx;
      logic              rpres;
      logic [NODE_W-1:0] ridx;
      logic [6:0]        sym;
   } entry_type;

   entry_type node;
   logic      is_leaf;
   logic      child_pres;

   assign node       = entry_type'(entry);
   assign is_leaf    = !node.lpres && !node.rpres;
   assign child_pres = bit_in ? node.rpres : node.lpres;
   assign next_idx   = bit_in ? node.ridx : node.lidx;

   always_comb begin
      ctl = '0;
      if (chk && is_leaf) begin
         ctl.leaf_hit = 1'b1;
      end else if (bits_left != 4'd0) begin
         ctl.consume = 1'b1;
         ctl.bad     = !child_pres;
      end else begin
         ctl.done = 1'b1;
      end
   end

endmodule

### sv/huffman_tree_walk_decoder_core.sv
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_core: Huffman decoder walking a node table
// Loads tree nodes, decodes coded bytes bit by bit, restarts the walk.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: a node load (op load), a coded byte
//   with its count of leading valid bits (op decode) or a walk restart
//   (op restart). rsp_* carries one result per decoded symbol or bad code;
//   the final result of a decode item has last set. Load, restart and a
//   decode that reaches no leaf and no absent child give no result.
//   Load and restart leave req_stall low. A decode item is taken and
//   then holds req_stall high while the step unit walks its saturated
//   bit count: it consumes each bit, takes a return step per leaf reached
//   to move back to the root, and ends with a step that finds no bits left;
//   a full output register can pause the walk. The node table has one
//   registered read port, so every step waits on the previous read. The
//   final step hands the last result to the output register, so it shows
//   on rsp_valid in the same cycle that req_stall drops.
//   Reset returns the walk to the root and empties the output register;
//   the node table holds garbage until loaded.
//   When rsp_stall holds a result in the output register, the walk pauses
//   on the next result it has to hand over and resumes once it can.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_core #(
   parameter int NODE_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  htw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output htw_pkg::rsp_type rsp_data
);

   localparam int NODE_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int ENTRY_W = 2 * NODE_W + 9;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   typedef struct packed {
      logic              lpres;
      logic [NODE_W-1:0] lidx;
      logic              rpres;
      logic [NODE_W-1:0] ridx;
      logic [6:0]        sym;
   } entry_type;

   // Reduce an 8-bit node index modulo NODE_COUNT by conditional subtraction.
   function automatic logic [NODE_W-1:0] node_slot(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      for (int k = 7; k >= 0; k--) begin
         if ({24'd0, r} >= 32'(NODE_COUNT << k)) begin
            r = r - 8'(NODE_COUNT << k);
         end
      end
      return NODE_W'(r);
   endfunction

   // Sequencer state
   logic                state_ff, state_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic                chk_ff, chk_in;
   logic [7:0]          data_ff, data_in;
   logic [3:0]          left_ff, left_in;

   // Result held back until we know whether another follows it
   logic                pend_v_ff, pend_v_in;
   htw_pkg::rsp_type    pend_ff, pend_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   htw_pkg::rsp_type    rsp_ff, rsp_in;

   // Node table and step unit
   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   entry_type           wr_entry;
   logic [NODE_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   entry_type           rd_entry;
   htw_pkg::step_ctl_type ctl;
   logic [NODE_W-1:0]   next_idx;

   logic                req_xfer;
   logic                can_push;
   logic                need_push;
   logic                walk_hold;
   logic [3:0]          sat_count;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign can_push  = !rsp_valid_ff || !rsp_stall;
   assign rd_entry  = entry_type'(rd_data);
   assign sat_count = (req_data.bit_count > htw_pkg::MAX_BITS) ?
                      htw_pkg::MAX_BITS : req_data.bit_count;

   // Load writes one node; presence bits keep the raw zero test of the links.
   assign wr_en          = req_xfer && (req_data.op == htw_pkg::OP_LOAD);
   assign wr_addr        = node_slot(req_data.node_index);
   assign wr_entry.lpres = (req_data.left_child != 8'd0);
   assign wr_entry.lidx  = node_slot(req_data.left_child);
   assign wr_entry.rpres = (req_data.right_child != 8'd0);
   assign wr_entry.ridx  = node_slot(req_data.right_child);
   assign wr_entry.sym   = req_data.leaf_symbol;

   htw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   htw_step #(
      .NODE_W (NODE_W)
   ) u_step (
      .entry     (rd_data),
      .chk       (chk_ff),
      .bits_left (left_ff),
      .bit_in    (data_ff[htw_pkg::TOP_BIT]),
      .ctl       (ctl),
      .next_idx  (next_idx)
   );

   // A new event or the end of the walk hands the pending result over.
   assign need_push = (state_ff == ST_WALK) && pend_v_ff &&
                      (ctl.leaf_hit || (ctl.consume && ctl.bad) || ctl.done);
   assign walk_hold = need_push && !can_push;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      chk_in       = chk_ff;
      data_in      = data_ff;
      left_in      = left_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_data.op)
                  htw_pkg::OP_DECODE: begin
                     // Read the current node; its entry arrives next cycle.
                     state_in = ST_WALK;
                     chk_in   = 1'b0;
                     data_in  = req_data.data_byte;
                     left_in  = sat_count;
                  end
                  htw_pkg::OP_RESTART: begin
                     cur_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (!walk_hold) begin
               if (need_push) begin
                  rsp_in       = pend_ff;
                  rsp_in.last  = ctl.done;
                  rsp_valid_in = 1'b1;
               end
               if (ctl.leaf_hit) begin
                  // Emit the leaf symbol, return to the root.
                  pend_v_in            = 1'b1;
                  pend_in.symbol       = rd_entry.sym;
                  pend_in.symbol_valid = 1'b1;
                  pend_in.bad_code     = 1'b0;
                  pend_in.last         = 1'b0;
                  cur_in               = '0;
                  chk_in               = 1'b0;
                  rd_addr              = '0;
               end else if (ctl.consume) begin
                  data_in = {data_ff[6:0], 1'b0};
                  left_in = left_ff - 4'd1;
                  if (ctl.bad) begin
                     // Absent child: flag it and restart at the root.
                     pend_v_in            = 1'b1;
                     pend_in.symbol       = '0;
                     pend_in.symbol_valid = 1'b0;
                     pend_in.bad_code     = 1'b1;
                     pend_in.last         = 1'b0;
                     cur_in               = '0;
                     chk_in               = 1'b0;
                     rd_addr              = '0;
                  end else begin
                     cur_in  = next_idx;
                     chk_in  = 1'b1;
                     rd_addr = next_idx;
                  end
               end else begin
                  state_in  = ST_IDLE;
                  pend_v_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         chk_ff       <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         chk_ff       <= chk_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      left_ff <= left_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/htw_checker.sv
// ----------------------------------------------------------------------------
// htw_checker: port-level checks for the Huffman tree walk decoder
// Watches handshakes and results over time; bound to the core.
// ----------------------------------------------------------------------------
module htw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input htw_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input htw_pkg::rsp_type rsp_data
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A decode transfer keeps the block busy in the following cycle.
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == htw_pkg::OP_DECODE)
      |=> req_stall)
      else $error("decode did not occupy the walker");

   // Load and restart finish at once.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      ((req_data.op == htw_pkg::OP_LOAD) || (req_data.op == htw_pkg::OP_RESTART))
      |=> !req_stall)
      else $error("load or restart held the request channel");

   // Reset empties the output and frees the input.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset left the block busy");

   // A result is a symbol or a bad code, never both.
   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.symbol_valid && rsp_data.bad_code))
      else $error("response marked both symbol and bad code");

endmodule

bind huffman_tree_walk_decoder_core htw_checker u_htw_checker (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for huffman_tree_walk_decoder_core
// Loads code trees into the node table, feeds coded bytes, restarts and
// ignored items, and checks every symbol and bad-code result against typed-in
// results or a tree walk kept in the bench, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   // Code 3 has no meaning; the block must ignore it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES = 8;
   // Longest walk: the item taken, eight bits, eight leaf returns, the output.
   localparam int WALK_LATENCY = 1 + 8 + 8 + 1;
   localparam int HOLD_CYCLES  = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 224;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   htw_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   htw_pkg::rsp_type rsp_data;

   always #5 clock = ~clock;

   huffman_tree_walk_decoder_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Tree walk kept by the bench: node table, walk position, and the
   // symbols and bad codes still awaited from the block, oldest first.
   // -------------------------------------------------------------------------
   logic [7:0]       left_of   [256];
   logic [7:0]       right_of  [256];
   logic [6:0]       symbol_of [256];
   bit               is_loaded [256];
   logic [7:0]       loaded_list [$];
   logic [7:0]       walk_at = '0;
   htw_pkg::rsp_type walk_events [$];
   htw_pkg::rsp_type awaited_symbols [$];

   // Stimulus bookkeeping
   bit         tree_taken [256];
   bit         no_idle = 1'b0;
   int         holds_requested = 0;
   int         holds_served = 0;
   int         hold_left = 0;
   int         dead_cycles = 0;
   int         mismatches = 0;
   int         items_moved = 0;
   int         loads = 0, decodes_done = 0, restarts = 0, ignored = 0;
   int         symbols_seen = 0, bad_seen = 0, trees_built = 0;

   typedef struct {
      htw_pkg::req_type item;
      bit               known;     // expected results typed in below
      int               n_known;   // number of copies of pattern, last on the final one
      htw_pkg::rsp_type pattern;
   } stim_row_type;

   stim_row_type plan [$];

   function automatic htw_pkg::rsp_type code_event(logic [6:0] sym, logic valid,
                                                   logic bad);
      return '{symbol: sym, symbol_valid: valid, bad_code: bad, last: 1'b0};
   endfunction

   // Walk one item through the bench's tree; results land in walk_events.
   task automatic walk_code_tree(input htw_pkg::req_type item);
      logic [3:0] nbits;
      logic [7:0] child;
      int         n;
      walk_events.delete();
      case (item.op)
         htw_pkg::OP_LOAD: begin
            left_of[item.node_index]   = item.left_child;
            right_of[item.node_index]  = item.right_child;
            symbol_of[item.node_index] = item.leaf_symbol;
            if (!is_loaded[item.node_index]) begin
               is_loaded[item.node_index] = 1'b1;
               loaded_list.push_back(item.node_index);
            end
         end
         htw_pkg::OP_RESTART: walk_at = '0;
         htw_pkg::OP_DECODE: begin
            // saturate the bit count, then take bits MSB first
            nbits = (item.bit_count > htw_pkg::MAX_BITS) ? htw_pkg::MAX_BITS
                                                          : item.bit_count;
            for (n = 0; n < nbits; n++) begin
               child = item.data_byte[htw_pkg::TOP_BIT - n] ? right_of[walk_at]
                                                            : left_of[walk_at];
               if (child == '0) begin
                  // absent child: flag a bad code and go back to the root
                  walk_events.push_back(code_event('0, 1'b0, 1'b1));
                  walk_at = '0;
               end else if (left_of[child] == '0 && right_of[child] == '0) begin
                  walk_events.push_back(code_event(symbol_of[child], 1'b1, 1'b0));
                  walk_at = '0;
               end else begin
                  walk_at = child;
               end
            end
            if (walk_events.size() != 0)
               walk_events[walk_events.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic htw_pkg::req_type make_req(logic [1:0] op, logic [7:0] idx,
                                                 logic [7:0] left, logic [7:0] right,
                                                 logic [6:0] sym, logic [7:0] data,
                                                 logic [3:0] cnt);
      return '{op: op, node_index: idx, left_child: left, right_child: right,
               leaf_symbol: sym, data_byte: data, bit_count: cnt};
   endfunction

   // Fill every field at random so unused fields toggle too.
   function automatic htw_pkg::req_type random_req(logic [1:0] op);
      return make_req(op, 8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom),
                      8'($urandom), 4'($urandom));
   endfunction

   // Child for a stray load: absent, or any node already loaded, so that
   // no walk ever reads a table entry that was never written.
   function automatic logic [7:0] pick_child();
      if ($urandom_range(0, 3) == 0)
         return 8'd0;
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   function automatic logic [7:0] fresh_node();
      logic [7:0] idx;
      do idx = 8'($urandom_range(1, 255)); while (tree_taken[idx]);
      tree_taken[idx] = 1'b1;
      return idx;
   endfunction

   function automatic void plan_row(htw_pkg::req_type item, bit known = 1'b0,
                                    int n_known = 0, htw_pkg::rsp_type pattern = '0);
      plan.push_back('{item: item, known: known, n_known: n_known, pattern: pattern});
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // -------------------------------------------------------------------------
   // Request side: offer one item, hold it until the transfer, then queue
   // what it should produce. Starts and ends on a rising edge.
   // -------------------------------------------------------------------------
   task automatic send(input htw_pkg::req_type item, input bit known = 1'b0,
                       input int n_known = 0, input htw_pkg::rsp_type pattern = '0);
      htw_pkg::rsp_type ev;
      int               k;
      if (!no_idle && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      walk_code_tree(item);
      if (known) begin
         for (k = 0; k < n_known; k++) begin
            ev = pattern;
            ev.last = (k == n_known - 1);
            awaited_symbols.push_back(ev);
         end
      end else begin
         foreach (walk_events[i]) awaited_symbols.push_back(walk_events[i]);
      end
      case (item.op)
         htw_pkg::OP_LOAD:    loads++;
         htw_pkg::OP_DECODE:  decodes_done++;
         htw_pkg::OP_RESTART: restarts++;
         default:             ignored++;
      endcase
      if (item.op != OP_UNUSED)
         items_moved++;
   endtask

   task automatic load_node(input logic [7:0] idx, input logic [7:0] left,
                            input logic [7:0] right);
      htw_pkg::req_type item;
      item             = random_req(htw_pkg::OP_LOAD);
      item.node_index  = idx;
      item.left_child  = left;
      item.right_child = right;
      send(item);
   endtask

   // Lower valid and wait until every awaited result has arrived.
   // Sample the queue on the falling edge, clear of the checker's update.
   task automatic drain_walk();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaited_symbols.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Build a random code tree bottom-up, children before parents, root last
   // at node 0. Some inner nodes get one child only, so bad codes show up.
   task automatic grow_tree();
      logic [7:0] tops [$];
      logic [7:0] idx;
      int         leaves, a, b;
      foreach (tree_taken[i]) tree_taken[i] = (i == 0);
      leaves = $urandom_range(0, 10);
      trees_built++;
      if (leaves == 0) begin
         // root alone is a leaf: every bit is a bad code
         load_node(8'd0, 8'd0, 8'd0);
      end else begin
         repeat (leaves) begin
            idx = fresh_node();
            load_node(idx, 8'd0, 8'd0);
            tops.push_back(idx);
         end
         while (tops.size() > 2) begin
            a   = $urandom_range(0, tops.size() - 1);
            idx = fresh_node();
            if ($urandom_range(0, 4) == 0) begin
               if ($urandom_range(0, 1) != 0) load_node(idx, tops[a], 8'd0);
               else load_node(idx, 8'd0, tops[a]);
               tops[a] = idx;
            end else begin
               do b = $urandom_range(0, tops.size() - 1); while (b == a);
               load_node(idx, tops[a], tops[b]);
               tops[a] = idx;
               tops.delete(b);
            end
         end
         if (tops.size() == 2) load_node(8'd0, tops[0], tops[1]);
         else if ($urandom_range(0, 1) != 0) load_node(8'd0, tops[0], 8'd0);
         else load_node(8'd0, 8'd0, tops[0]);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: check each transfer against the oldest awaited result,
   // then drive stall: a requested long hold first, else random idling.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      htw_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_symbols.size() == 0) begin
            report_mismatch($sformatf("unexpected result sym=%0d valid=%b bad=%b last=%b",
                                      rsp_data.symbol, rsp_data.symbol_valid,
                                      rsp_data.bad_code, rsp_data.last));
         end else begin
            want = awaited_symbols.pop_front();
            if (rsp_data.symbol !== want.symbol ||
                rsp_data.symbol_valid !== want.symbol_valid ||
                rsp_data.bad_code !== want.bad_code || rsp_data.last !== want.last)
               report_mismatch($sformatf(
                  "got sym=%0d valid=%b bad=%b last=%b, want sym=%0d valid=%b bad=%b last=%b",
                  rsp_data.symbol, rsp_data.symbol_valid, rsp_data.bad_code, rsp_data.last,
                  want.symbol, want.symbol_valid, want.bad_code, want.last));
            if (want.bad_code) bad_seen++;
            else symbols_seen++;
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         // start a long hold: the block must fill up and stall its input
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 6);
      end
   end

   // Watchdog: count cycles in which neither channel makes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         dead_cycles <= 0;
      else
         dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
         $display("** huffman_tree_walk_decoder_core: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      htw_pkg::rsp_type sym_zero, sym_top, bad_walk;
      htw_pkg::req_type item;
      int               phase, decodes, d, pick, first_random;

      sym_zero = code_event(7'd0, 1'b1, 1'b0);
      sym_top  = code_event(7'd127, 1'b1, 1'b0);
      bad_walk = code_event(7'd0, 1'b0, 1'b1);

      // Directed tree: 00 -> symbol 0, 01 and 10 -> symbol 127, 11 -> bad code.
      // Node 255 is the top leaf; node 2 has no right child.
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd255, 8'd0, 8'd0, 7'd127, 8'hFF, 4'hF));
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd1, 8'd0, 8'd0, 7'd0, 8'h00, 4'h0));
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd4, 8'd1, 8'd255, 7'd42, 8'h00, 4'h0));
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd2, 8'd255, 8'd0, 7'd0, 8'h00, 4'h0));
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd0, 8'd4, 8'd2, 7'd0, 8'h00, 4'h0));
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd8),
               1'b1, 4, sym_zero);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'hFF, 4'd8),
               1'b1, 4, bad_walk);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h55, 4'd8),
               1'b1, 4, sym_top);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'hAA, 4'd8),
               1'b1, 4, sym_top);
      // position carries across bytes: "1" then "0"
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h80, 4'd1),
               1'b1, 0);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd1),
               1'b1, 1, sym_top);
      // restart mid-code: "1", restart, then "00" from the root
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h80, 4'd1),
               1'b1, 0);
      plan_row(make_req(htw_pkg::OP_RESTART, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd0),
               1'b1, 0);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd1),
               1'b1, 0);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd1),
               1'b1, 1, sym_zero);
      // zero bits consume nothing; counts above eight saturate
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'hFF, 4'd0),
               1'b1, 0);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd15),
               1'b1, 4, sym_zero);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'hFF, 4'd9),
               1'b1, 4, bad_walk);
      // unused op: taken as a load it would turn the root into a leaf
      plan_row(make_req(OP_UNUSED, 8'd0, 8'd0, 8'd0, 7'd0, 8'h00, 4'd0), 1'b1, 0);
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h55, 4'd8),
               1'b1, 4, sym_top);
      // mixed symbols, bad codes and a code left open across bytes
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h6C, 4'd7));
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h3F, 4'd8));
      // reload the root with one child: one symbol then seven bad codes
      plan_row(make_req(htw_pkg::OP_LOAD, 8'd0, 8'd1, 8'd0, 7'd0, 8'h00, 4'h0));
      plan_row(make_req(htw_pkg::OP_DECODE, 8'd0, 8'd0, 8'd0, 7'd0, 8'h7F, 4'd8));

      // Hold reset, then release it on a rising edge.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send(plan[i].item, plan[i].known, plan[i].n_known, plan[i].pattern);

      // Random part: mostly well-formed trees followed by coded bytes, with
      // stray loads, restarts, odd bit counts and ignored items mixed in.
      first_random = items_moved;
      phase = 0;
      while (items_moved - first_random < RANDOM_ITEMS) begin
         no_idle <= (phase == 1);
         grow_tree();
         if (phase == 0 || $urandom_range(0, 2) == 0)
            send(random_req(htw_pkg::OP_RESTART));
         if (phase == 2)
            holds_requested <= holds_requested + 1;
         decodes = $urandom_range(8, 16);
         for (d = 0; d < decodes; d++) begin
            if (phase == 3 && d == decodes / 2)
               drain_walk();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               item = random_req(htw_pkg::OP_DECODE);
               item.bit_count = htw_pkg::MAX_BITS;
            end else if (pick < 82) begin
               item = random_req(htw_pkg::OP_DECODE);
            end else if (pick < 88) begin
               item = random_req(htw_pkg::OP_RESTART);
            end else if (pick < 94) begin
               item = random_req(htw_pkg::OP_LOAD);
               item.left_child  = pick_child();
               item.right_child = pick_child();
            end else begin
               item = random_req(OP_UNUSED);
            end
            send(item);
         end
         if ($urandom_range(0, 3) == 0)
            drain_walk();
         phase++;
      end

      // Let the last results arrive, then watch for strays.
      drain_walk();
      repeat (WALK_LATENCY + 6) @(posedge clock);

      $display("Run covered %0d loads, %0d decodes, %0d restarts, %0d ignored items, %0d trees.",
               loads, decodes_done, restarts, ignored, trees_built);
      $display("Checked %0d symbols and %0d bad codes; %0d mismatches.",
               symbols_seen, bad_seen, mismatches);
      if (mismatches == 0 && awaited_symbols.size() == 0)
         $display("** huffman_tree_walk_decoder_core: PASSED **");
      else
         $display("** huffman_tree_walk_decoder_core: FAILED **");
      $finish;
   end

endmodule
